// ===== rtl/core/assert_macros.svh =====
// Assertion macros for the checker file rpnh_checker.sv.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, sampled on clk, off while rst_n is low.
`define RPNH_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk, off while rst_n is low.
`define RPNH_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/core/rpnh_pkg.sv =====
// Shared widths and constants for the ray/polygon nearest-hit block.
package rpnh_pkg;

  localparam int COORD_W       = 32;              // input coordinate width
  localparam int DIFF_W        = COORD_W + 1;     // difference of two coordinates
  localparam int SUM_W         = 2 * DIFF_W + 1;  // difference of two products
  localparam int T_W           = 31;              // distance field width
  localparam int DV_W          = SUM_W + T_W;     // divider datapath width
  localparam int FRAC_BITS_DEF = 16;

  localparam logic [T_W-1:0] T_MAX = {T_W{1'b1}};

endpackage

// ===== rtl/core/ray_polygon_nearest_hit.sv =====
// Nearest hit of a 2-D ray on a polygon outline, one shared multiplier and a serial divider.
// Vertices arrive one per transaction; the ray is taken with the first vertex of each
// polygon, and the vertex flagged last also closes the outline back to the first vertex and
// produces one result (hit flag and nearest ray parameter t, Q format with FRAC_BITS
// fraction bits, saturated at 2^31-1, zero when nothing is hit). A first vertex that is not
// last is only registered. Every edge runs a setup step, six passes through the single
// 33x33 signed multiplier with its accumulator, a check and a divisor load, then a
// restoring divider that tests for saturation and then retires one quotient bit per cycle,
// and an update and a next-edge step; an edge parallel to the ray or missed is dropped
// after the check, and a saturated quotient ends the divide after its first step. The last
// vertex runs its forward edge (none when it is also the first) and then its closing edge
// before it posts the result. in_ready is high only in the idle state; a posted result
// waits in the output register while the next vertex is taken.
module ray_polygon_nearest_hit #(
  parameter int FRAC_BITS = rpnh_pkg::FRAC_BITS_DEF
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 in_valid,
  output logic                                 in_ready,
  input  logic signed [rpnh_pkg::COORD_W-1:0]  in_ray_origin_x,
  input  logic signed [rpnh_pkg::COORD_W-1:0]  in_ray_origin_y,
  input  logic signed [rpnh_pkg::COORD_W-1:0]  in_ray_dir_x,
  input  logic signed [rpnh_pkg::COORD_W-1:0]  in_ray_dir_y,
  input  logic signed [rpnh_pkg::COORD_W-1:0]  in_vertex_x,
  input  logic signed [rpnh_pkg::COORD_W-1:0]  in_vertex_y,
  input  logic                                 in_last_vertex,
  output logic                                 out_valid,
  input  logic                                 out_ready,
  output logic                                 out_hit,
  output logic        [rpnh_pkg::T_W-1:0]      out_distance
);
  import rpnh_pkg::*;

  localparam int CNT_W = $clog2(T_W + 1);
  localparam logic [CNT_W-1:0] CNT_TOP = CNT_W'(T_W);

  localparam logic [3:0] S_IDLE   = 4'd0;
  localparam logic [3:0] S_SETUP  = 4'd1;
  localparam logic [3:0] S_MUL    = 4'd2;
  localparam logic [3:0] S_CHECK  = 4'd3;
  localparam logic [3:0] S_DLOAD  = 4'd4;
  localparam logic [3:0] S_DIV    = 4'd5;
  localparam logic [3:0] S_UPDATE = 4'd6;
  localparam logic [3:0] S_NEXT   = 4'd7;
  localparam logic [3:0] S_FINISH = 4'd8;

  // Multiplier passes: den = ex*dy - ey*dx, num = ex*wy - ey*wx, un = dx*wy - dy*wx.
  localparam logic [2:0] MS_DEN_A = 3'd0;
  localparam logic [2:0] MS_DEN_B = 3'd1;
  localparam logic [2:0] MS_NUM_A = 3'd2;
  localparam logic [2:0] MS_NUM_B = 3'd3;
  localparam logic [2:0] MS_UN_A  = 3'd4;
  localparam logic [2:0] MS_UN_B  = 3'd5;

  logic [3:0] state_r, state_nxt;
  logic       mid_r, mid_nxt;
  logic       closing_r, closing_nxt;
  logic       last_r, last_nxt;
  logic       found_r, found_nxt;
  logic       out_valid_r, out_valid_nxt;

  logic signed [COORD_W-1:0] org_x_r, org_x_nxt, org_y_r, org_y_nxt;
  logic signed [COORD_W-1:0] dir_x_r, dir_x_nxt, dir_y_r, dir_y_nxt;
  logic signed [COORD_W-1:0] first_x_r, first_x_nxt, first_y_r, first_y_nxt;
  logic signed [COORD_W-1:0] prev_x_r, prev_x_nxt, prev_y_r, prev_y_nxt;
  logic signed [COORD_W-1:0] cur_x_r, cur_x_nxt, cur_y_r, cur_y_nxt;
  logic signed [DIFF_W-1:0]  ex_r, ex_nxt, ey_r, ey_nxt, wx_r, wx_nxt, wy_r, wy_nxt;
  logic        [2:0]         mstep_r, mstep_nxt;
  logic signed [SUM_W-1:0]   acc_r, acc_nxt, den_r, den_nxt, num_r, num_nxt, un_r, un_nxt;
  logic        [DV_W-1:0]    rem_r, rem_nxt, dsh_r, dsh_nxt;
  logic        [T_W-1:0]     q_r, q_nxt, best_r, best_nxt;
  logic        [CNT_W-1:0]   cnt_r, cnt_nxt;
  logic                      out_hit_r, out_hit_nxt;
  logic        [T_W-1:0]     out_distance_r, out_distance_nxt;

  logic signed [DIFF_W-1:0]   mul_a, mul_b;
  logic signed [2*DIFF_W-1:0] mul_p;
  logic signed [SUM_W-1:0]    prod_ext, acc_diff;
  logic signed [SUM_W-1:0]    num_mag, den_mag;
  logic signed [COORD_W-1:0]  edge_ax, edge_ay, edge_bx, edge_by;
  logic        [DV_W-1:0]     dv_sub;
  logic                       dv_ge;
  logic                       den_zero, den_neg, num_ok, un_ok;
  logic                       in_acc;

  assign in_ready     = (state_r == S_IDLE);
  assign in_acc       = in_valid && in_ready;
  assign out_valid    = out_valid_r;
  assign out_hit      = out_hit_r;
  assign out_distance = out_distance_r;

  // Shared multiplier operand select.
  always_comb begin
    case (mstep_r)
      MS_DEN_A: begin mul_a = ex_r;                     mul_b = {dir_y_r[COORD_W-1], dir_y_r}; end
      MS_DEN_B: begin mul_a = ey_r;                     mul_b = {dir_x_r[COORD_W-1], dir_x_r}; end
      MS_NUM_A: begin mul_a = ex_r;                     mul_b = wy_r; end
      MS_NUM_B: begin mul_a = ey_r;                     mul_b = wx_r; end
      MS_UN_A:  begin mul_a = {dir_x_r[COORD_W-1], dir_x_r}; mul_b = wy_r; end
      MS_UN_B:  begin mul_a = {dir_y_r[COORD_W-1], dir_y_r}; mul_b = wx_r; end
      default:  begin mul_a = ex_r;                     mul_b = wy_r; end
    endcase
  end

  assign mul_p    = mul_a * mul_b;
  assign prod_ext = SUM_W'(mul_p);
  assign acc_diff = acc_r - prod_ext;

  // Edge endpoints: forward edge prev->cur, closing edge cur->first.
  assign edge_ax = closing_r ? cur_x_r   : prev_x_r;
  assign edge_ay = closing_r ? cur_y_r   : prev_y_r;
  assign edge_bx = closing_r ? first_x_r : cur_x_r;
  assign edge_by = closing_r ? first_y_r : cur_y_r;

  // Hit test with the sign of den folded in.
  assign den_zero = (den_r == '0);
  assign den_neg  = den_r[SUM_W-1];
  assign num_ok   = den_neg ? (num_r[SUM_W-1] || (num_r == '0)) : !num_r[SUM_W-1];
  assign un_ok    = den_neg ? ((un_r[SUM_W-1] || (un_r == '0)) && (un_r >= den_r))
                            : (!un_r[SUM_W-1] && (un_r <= den_r));
  assign num_mag  = den_neg ? -num_r : num_r;
  assign den_mag  = den_neg ? -den_r : den_r;

  // One restoring divider step.
  assign dv_ge  = (rem_r >= dsh_r);
  assign dv_sub = rem_r - dsh_r;

  always_comb begin
    state_nxt        = state_r;
    mid_nxt          = mid_r;
    closing_nxt      = closing_r;
    last_nxt         = last_r;
    found_nxt        = found_r;
    out_valid_nxt    = out_valid_r;
    org_x_nxt        = org_x_r;
    org_y_nxt        = org_y_r;
    dir_x_nxt        = dir_x_r;
    dir_y_nxt        = dir_y_r;
    first_x_nxt      = first_x_r;
    first_y_nxt      = first_y_r;
    prev_x_nxt       = prev_x_r;
    prev_y_nxt       = prev_y_r;
    cur_x_nxt        = cur_x_r;
    cur_y_nxt        = cur_y_r;
    ex_nxt           = ex_r;
    ey_nxt           = ey_r;
    wx_nxt           = wx_r;
    wy_nxt           = wy_r;
    mstep_nxt        = mstep_r;
    acc_nxt          = acc_r;
    den_nxt          = den_r;
    num_nxt          = num_r;
    un_nxt           = un_r;
    rem_nxt          = rem_r;
    dsh_nxt          = dsh_r;
    q_nxt            = q_r;
    best_nxt         = best_r;
    cnt_nxt          = cnt_r;
    out_hit_nxt      = out_hit_r;
    out_distance_nxt = out_distance_r;

    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end

    unique case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          cur_x_nxt = in_vertex_x;
          cur_y_nxt = in_vertex_y;
          last_nxt  = in_last_vertex;
          if (!mid_r) begin
            org_x_nxt   = in_ray_origin_x;
            org_y_nxt   = in_ray_origin_y;
            dir_x_nxt   = in_ray_dir_x;
            dir_y_nxt   = in_ray_dir_y;
            first_x_nxt = in_vertex_x;
            first_y_nxt = in_vertex_y;
            prev_x_nxt  = in_vertex_x;
            prev_y_nxt  = in_vertex_y;
            best_nxt    = T_MAX;
            found_nxt   = 1'b0;
            mid_nxt     = 1'b1;
            closing_nxt = 1'b1;
            state_nxt   = in_last_vertex ? S_SETUP : S_IDLE;
          end else begin
            closing_nxt = 1'b0;
            state_nxt   = S_SETUP;
          end
        end
      end
      S_SETUP: begin
        ex_nxt     = {edge_bx[COORD_W-1], edge_bx} - {edge_ax[COORD_W-1], edge_ax};
        ey_nxt     = {edge_by[COORD_W-1], edge_by} - {edge_ay[COORD_W-1], edge_ay};
        wx_nxt     = {edge_ax[COORD_W-1], edge_ax} - {org_x_r[COORD_W-1], org_x_r};
        wy_nxt     = {edge_ay[COORD_W-1], edge_ay} - {org_y_r[COORD_W-1], org_y_r};
        prev_x_nxt = cur_x_r;
        prev_y_nxt = cur_y_r;
        mstep_nxt  = MS_DEN_A;
        state_nxt  = S_MUL;
      end
      S_MUL: begin
        case (mstep_r)
          MS_DEN_B: den_nxt = acc_diff;
          MS_NUM_B: num_nxt = acc_diff;
          MS_UN_B:  un_nxt  = acc_diff;
          default:  acc_nxt = prod_ext;
        endcase
        mstep_nxt = mstep_r + 3'd1;
        if (mstep_r == MS_UN_B) begin
          state_nxt = S_CHECK;
        end
      end
      S_CHECK: begin
        if (den_zero || !num_ok || !un_ok) begin
          state_nxt = S_NEXT;
        end else begin
          rem_nxt   = {{(DV_W-SUM_W){1'b0}}, num_mag} << FRAC_BITS;
          state_nxt = S_DLOAD;
        end
      end
      S_DLOAD: begin
        dsh_nxt   = {{(DV_W-SUM_W){1'b0}}, den_mag} << T_W;
        cnt_nxt   = CNT_TOP;
        q_nxt     = '0;
        state_nxt = S_DIV;
      end
      S_DIV: begin
        if (dv_ge) begin
          rem_nxt = dv_sub;
        end
        dsh_nxt = dsh_r >> 1;
        cnt_nxt = cnt_r - 1'b1;
        if (cnt_r == CNT_TOP) begin
          // Top step only tests for a quotient past the field range.
          if (dv_ge) begin
            q_nxt     = T_MAX;
            state_nxt = S_UPDATE;
          end
        end else begin
          q_nxt = {q_r[T_W-2:0], dv_ge};
          if (cnt_r == '0) begin
            state_nxt = S_UPDATE;
          end
        end
      end
      S_UPDATE: begin
        if (q_r < best_r) begin
          best_nxt = q_r;
        end
        found_nxt = 1'b1;
        state_nxt = S_NEXT;
      end
      S_NEXT: begin
        if (last_r && !closing_r) begin
          closing_nxt = 1'b1;
          state_nxt   = S_SETUP;
        end else if (last_r) begin
          state_nxt = S_FINISH;
        end else begin
          state_nxt = S_IDLE;
        end
      end
      S_FINISH: begin
        // Hold until the output register is free.
        if (!out_valid_r || out_ready) begin
          out_valid_nxt    = 1'b1;
          out_hit_nxt      = found_r;
          out_distance_nxt = found_r ? best_r : '0;
          mid_nxt          = 1'b0;
          state_nxt        = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      mid_r       <= 1'b0;
      closing_r   <= 1'b0;
      last_r      <= 1'b0;
      found_r     <= 1'b0;
      out_valid_r <= 1'b0;
      best_r      <= T_MAX;
      org_x_r     <= '0;
      org_y_r     <= '0;
      dir_x_r     <= '0;
      dir_y_r     <= '0;
      first_x_r   <= '0;
      first_y_r   <= '0;
      prev_x_r    <= '0;
      prev_y_r    <= '0;
      mstep_r     <= MS_DEN_A;
      cnt_r       <= '0;
    end else begin
      state_r     <= state_nxt;
      mid_r       <= mid_nxt;
      closing_r   <= closing_nxt;
      last_r      <= last_nxt;
      found_r     <= found_nxt;
      out_valid_r <= out_valid_nxt;
      best_r      <= best_nxt;
      org_x_r     <= org_x_nxt;
      org_y_r     <= org_y_nxt;
      dir_x_r     <= dir_x_nxt;
      dir_y_r     <= dir_y_nxt;
      first_x_r   <= first_x_nxt;
      first_y_r   <= first_y_nxt;
      prev_x_r    <= prev_x_nxt;
      prev_y_r    <= prev_y_nxt;
      mstep_r     <= mstep_nxt;
      cnt_r       <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cur_x_r        <= cur_x_nxt;
    cur_y_r        <= cur_y_nxt;
    ex_r           <= ex_nxt;
    ey_r           <= ey_nxt;
    wx_r           <= wx_nxt;
    wy_r           <= wy_nxt;
    acc_r          <= acc_nxt;
    den_r          <= den_nxt;
    num_r          <= num_nxt;
    un_r           <= un_nxt;
    rem_r          <= rem_nxt;
    dsh_r          <= dsh_nxt;
    q_r            <= q_nxt;
    out_hit_r      <= out_hit_nxt;
    out_distance_r <= out_distance_nxt;
  end

endmodule

// ===== rtl/core/rpnh_checker.sv =====
// Port-level assertions for the ray/polygon nearest-hit block, bound to its top level.
`include "assert_macros.svh"

module rpnh_checker (
  input logic                     clk,
  input logic                     rst_n,
  input logic                     in_valid,
  input logic                     in_ready,
  input logic                     in_last_vertex,
  input logic                     out_valid,
  input logic                     out_ready,
  input logic                     out_hit,
  input logic [rpnh_pkg::T_W-1:0] out_distance
);
  import rpnh_pkg::*;

  // A miss always reports a zero distance.
  `RPNH_ASSERT_NOW(a_miss_zero, out_valid && !out_hit, out_distance == '0, "miss with nonzero distance")

  // A stalled result holds its payload.
  `RPNH_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(out_hit) && $stable(out_distance), "result changed while stalled")

  // Closing a polygon always starts edge work, so input stalls next cycle.
  `RPNH_ASSERT_NEXT(a_last_busy, in_valid && in_ready && in_last_vertex, !in_ready, "input still ready after last vertex")

  // A new result is posted only out of the busy phase.
  `RPNH_ASSERT_NOW(a_post_busy, $rose(out_valid), !$past(in_ready), "result posted while idle")

endmodule

bind ray_polygon_nearest_hit rpnh_checker u_rpnh_checker (.*);

// ===== tb/sv/tb.sv =====
// Self-checking testbench for ray_polygon_nearest_hit: directed and random polygons, predicted nearest hits.
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import rpnh_pkg::*;

  typedef logic signed [COORD_W-1:0] coord_t;
  typedef coord_t coord_q[$];

  typedef struct packed {
    logic           hit;
    logic [T_W-1:0] distance;
  } hit_t;

  typedef enum int {SPAN_FULL, SPAN_NEAR, SPAN_GRID, SPAN_EDGE} span_e;

  localparam coord_t U    = 32'sh0001_0000;
  localparam coord_t CMAX = 32'sh7FFF_FFFF;
  localparam coord_t CMIN = 32'sh8000_0000;

  localparam int N_ITEMS   = 2000;
  localparam int HOLD_AT   = 400;
  localparam int STALL_LEN = 1500;
  localparam int CALM_FROM = 900;
  localparam int CALM_TO   = 1200;
  localparam int LIMIT     = 20000;
  localparam int MAX_LINES = 200;

  // Tracks the open polygon and the nearest hits still owed by the block.
  class hit_scoreboard;
    coord_t         first_x, first_y, prev_x, prev_y;
    coord_t         org_x, org_y, dir_x, dir_y;
    logic [T_W-1:0] best_t;
    bit             found, in_polygon;
    hit_t           hits_due[$];
    int             errors;

    function new();
      first_x = 0; first_y = 0; prev_x = 0; prev_y = 0;
      org_x = 0; org_y = 0; dir_x = 0; dir_y = 0;
      best_t = T_MAX;
      found = 0;
      in_polygon = 0;
      errors = 0;
    endfunction

    function int pending();
      return hits_due.size();
    endfunction

    task report(string msg);
      errors++;
      if (errors <= MAX_LINES) $display("%0t ERROR: %s", $time, msg);
    endtask

    // Exact edge test in 128-bit signed arithmetic.
    function void cross_edge(coord_t ax, coord_t ay, coord_t bx, coord_t by);
      logic signed [127:0] ax_w, ay_w, ex, ey, wx, wy, rx, ry, den, num, un, quo;
      logic [T_W-1:0]      t;
      ax_w = ax; ay_w = ay;
      ex = bx; ey = by;
      wx = org_x; wy = org_y;
      rx = dir_x; ry = dir_y;
      ex = ex - ax_w;
      ey = ey - ay_w;
      wx = ax_w - wx;
      wy = ay_w - wy;
      den = ex * ry - ey * rx;
      if (den == 0) return;
      num = ex * wy - ey * wx;
      un  = rx * wy - ry * wx;
      if (den < 0) begin
        den = -den;
        num = -num;
        un  = -un;
      end
      if (num < 0 || un < 0 || un > den) return;
      quo = (num <<< FRAC_BITS_DEF) / den;
      t = (quo > 128'sh7FFF_FFFF) ? T_MAX : quo[T_W-1:0];
      if (t < best_t) best_t = t;
      found = 1;
    endfunction

    function void take_vertex(coord_t ox, coord_t oy, coord_t rdx, coord_t rdy,
                              coord_t vx, coord_t vy, logic last);
      hit_t want;
      if (!in_polygon) begin
        org_x = ox; org_y = oy;
        dir_x = rdx; dir_y = rdy;
        first_x = vx; first_y = vy;
        best_t = T_MAX;
        found = 0;
        in_polygon = 1;
      end else begin
        cross_edge(prev_x, prev_y, vx, vy);
      end
      prev_x = vx;
      prev_y = vy;
      if (last) begin
        cross_edge(vx, vy, first_x, first_y);
        want.hit      = found;
        want.distance = found ? best_t : '0;
        hits_due.push_back(want);
        in_polygon = 0;
      end
    endfunction

    task check_hit(logic hit, logic [T_W-1:0] distance);
      hit_t want;
      if (hits_due.size() == 0) begin
        report($sformatf("result with no polygon closed: hit %0b distance %08h", hit,
                         distance));
        return;
      end
      want = hits_due.pop_front();
      if (hit !== want.hit)
        report($sformatf("hit flag %0b, predicted %0b", hit, want.hit));
      if (distance !== want.distance)
        report($sformatf("distance %08h, predicted %08h", distance, want.distance));
    endtask
  endclass

  logic           clk;
  logic           rst_n;
  logic           in_valid;
  logic           in_ready;
  coord_t         in_ray_origin_x, in_ray_origin_y, in_ray_dir_x, in_ray_dir_y;
  coord_t         in_vertex_x, in_vertex_y;
  logic           in_last_vertex;
  logic           out_valid;
  logic           out_ready;
  logic           out_hit;
  logic [T_W-1:0] out_distance;

  hit_scoreboard sb = new();
  int            sent;
  int            quiet_cycles;
  bit            calm;
  bit            stall_req;
  coord_q        xs, ys;

  ray_polygon_nearest_hit #(
    .FRAC_BITS(FRAC_BITS_DEF)
  ) i_dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_ray_origin_x(in_ray_origin_x),
    .in_ray_origin_y(in_ray_origin_y),
    .in_ray_dir_x   (in_ray_dir_x),
    .in_ray_dir_y   (in_ray_dir_y),
    .in_vertex_x    (in_vertex_x),
    .in_vertex_y    (in_vertex_y),
    .in_last_vertex (in_last_vertex),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_hit        (out_hit),
    .out_distance   (out_distance)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic coord_t rand_coord(span_e span);
    case (span)
      SPAN_FULL: return coord_t'($urandom);
      SPAN_NEAR: return coord_t'(int'($urandom_range(0, 1 << 20)) - (1 << 19));
      SPAN_GRID: return coord_t'((int'($urandom_range(0, 16)) - 8) * 65536);
      default: begin
        case ($urandom_range(0, 5))
          0:       return CMIN;
          1:       return CMAX;
          2:       return 0;
          3:       return 1;
          4:       return -1;
          default: return coord_t'($urandom);
        endcase
      end
    endcase
  endfunction

  // Ray fields are only meaningful on the first vertex; scramble them elsewhere.
  task automatic drive_polygon(input coord_t ox, input coord_t oy, input coord_t rdx,
                               input coord_t rdy, input coord_q vx, input coord_q vy);
    foreach (vx[i]) begin
      while (!calm && $urandom_range(0, 99) < 31) begin
        in_valid <= 1'b0;
        @(posedge clk);
      end
      in_valid        <= 1'b1;
      in_ray_origin_x <= (i == 0) ? ox  : coord_t'($urandom);
      in_ray_origin_y <= (i == 0) ? oy  : coord_t'($urandom);
      in_ray_dir_x    <= (i == 0) ? rdx : coord_t'($urandom);
      in_ray_dir_y    <= (i == 0) ? rdy : coord_t'($urandom);
      in_vertex_x     <= vx[i];
      in_vertex_y     <= vy[i];
      in_last_vertex  <= (i == vx.size() - 1);
      do @(posedge clk); while (!in_ready);
      sent++;
      if (sent == HOLD_AT) stall_req = 1'b1;
      calm = (sent >= CALM_FROM && sent < CALM_TO);
    end
  endtask

  // Receiver: random back-pressure plus one long hold-off on request.
  initial begin
    int stall_left;
    stall_left = 0;
    out_ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (stall_left > 0) begin
        stall_left--;
        out_ready <= 1'b0;
      end else if (stall_req) begin
        stall_req = 1'b0;
        stall_left = STALL_LEN;
        out_ready <= 1'b0;
      end else begin
        out_ready <= calm || ($urandom_range(0, 99) >= 31);
      end
    end
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if (in_valid && in_ready)
        sb.take_vertex(in_ray_origin_x, in_ray_origin_y, in_ray_dir_x, in_ray_dir_y,
                       in_vertex_x, in_vertex_y, in_last_vertex);
      if (out_valid && out_ready)
        sb.check_hit(out_hit, out_distance);
      if ((in_valid && in_ready) || (out_valid && out_ready))
        quiet_cycles = 0;
      else
        quiet_cycles++;
    end
  end

  initial begin
    quiet_cycles = 0;
    while (quiet_cycles < LIMIT) @(posedge clk);
    $display("tb NOT OK");
    $finish;
  end

  initial begin
    span_e span;
    int    n, r;
    sent = 0;
    calm = 1'b0;
    stall_req = 1'b0;
    rst_n           <= 1'b0;
    in_valid        <= 1'b0;
    in_ray_origin_x <= '0;
    in_ray_origin_y <= '0;
    in_ray_dir_x    <= '0;
    in_ray_dir_y    <= '0;
    in_vertex_x     <= '0;
    in_vertex_y     <= '0;
    in_last_vertex  <= 1'b0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // unit square around the origin, ray along +x; the bottom and top edges are parallel
    xs = {-U, U, U, -U};
    ys = {-U, -U, U, U};
    drive_polygon(0, 0, U, 0, xs, ys);
    // zero direction never hits
    xs = {-U, U, 0};
    ys = {-U, -U, U};
    drive_polygon(0, 0, 0, 0, xs, ys);
    // lone vertex: closing edge has no length
    xs = {3 * U};
    ys = {4 * U};
    drive_polygon(0, 0, U, U, xs, ys);
    // ray passes exactly through a vertex
    xs = {0, 2 * U, 0};
    ys = {0, 0, 2 * U};
    drive_polygon(-4 * U, -4 * U, U, U, xs, ys);
    // ray points away from the triangle
    drive_polygon(5 * U, 0, U, 0, xs, ys);
    // one-LSB direction toward a far edge: distance saturates
    xs = {32'sh7FFF_0000, 32'sh7FFF_0000};
    ys = {-U, U};
    drive_polygon(0, 0, 1, 0, xs, ys);
    // full-range square
    xs = {CMIN, CMAX, CMAX, CMIN};
    ys = {CMIN, CMIN, CMAX, CMAX};
    drive_polygon(0, 0, CMAX, CMIN, xs, ys);
    // origin sitting on an edge: t is zero
    xs = {U, U, -U};
    ys = {-U, U, 0};
    drive_polygon(U, 0, U, 0, xs, ys);
    // extreme origin and direction
    xs = {CMIN, CMAX};
    ys = {CMIN, CMAX};
    drive_polygon(CMAX, CMIN, CMIN, CMAX, xs, ys);

    while (sent < N_ITEMS) begin
      r = $urandom_range(0, 99);
      span = (r < 15) ? SPAN_FULL : (r < 60) ? SPAN_NEAR : (r < 90) ? SPAN_GRID : SPAN_EDGE;
      n = ($urandom_range(0, 9) == 0) ? $urandom_range(7, 16) : $urandom_range(1, 6);
      xs.delete();
      ys.delete();
      repeat (n) begin
        xs.push_back(rand_coord(span));
        ys.push_back(rand_coord(span));
      end
      drive_polygon(rand_coord(span), rand_coord(span), rand_coord(span), rand_coord(span),
                    xs, ys);
    end
    in_valid <= 1'b0;

    // drain, then give the block time to show any stray result
    while (sb.pending() != 0) @(posedge clk);
    repeat (200) @(posedge clk);
    if (sb.errors == 0)
      $display("tb OK");
    else
      $display("tb NOT OK");
    $finish;
  end

endmodule
